// ===== rtl/text_console_writer_assert.svh =====
// Assertion macros used by the checker file.
`ifndef TEXT_CONSOLE_WRITER_ASSERT_SVH
`define TEXT_CONSOLE_WRITER_ASSERT_SVH

// Condition and consequence in the same cycle.
`define TCW_ASSERT_NOW(lbl, clk, rst_n, cond, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
		else $error(msg);

// Consequence in the cycle after the condition.
`define TCW_ASSERT_NEXT(lbl, clk, rst_n, cond, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
		else $error(msg);

`endif

// ===== rtl/tcw_pkg.sv =====
package tcw_pkg;

	typedef enum logic [1:0] {
		OP_PUT     = 2'd0,
		OP_NEWLINE = 2'd1,
		OP_CLEAR   = 2'd2,
		OP_READ    = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		ST_INIT,
		ST_IDLE,
		ST_SCROLL,
		ST_BLANK,
		ST_POST,
		ST_RESP
	} state_t;

	localparam logic [7:0] NEWLINE_CODE = 8'd10;
	localparam logic [7:0] BLANK_CODE   = 8'd32;
	localparam logic [7:0] RESET_ATTR   = 8'd15;

	typedef struct packed {
		logic [7:0] attr;
		logic [7:0] code;
	} cell_t;

endpackage

// ===== rtl/tcw_screen_ram.sv =====
module tcw_screen_ram #(
	parameter int DEPTH  = 2000,
	parameter int ADDR_W = $clog2(DEPTH)
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  tcw_pkg::cell_t    wdata,
	input  logic              re,
	input  logic [ADDR_W-1:0] raddr,
	output tcw_pkg::cell_t    rdata
);
	import tcw_pkg::*;

	cell_t mem_q [DEPTH];
	cell_t rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== rtl/text_console_writer.sv =====
// Channel   Handshake             Payload
// config    cfg_we                cfg_wdata (text attribute)
// input     in_valid / in_ready   operation, char_code, cell_address
// output    out_valid / out_ready cursor_position, read_char, read_attribute
//
// One transaction at a time; put, new line and read go from ST_IDLE to ST_RESP.
// A scroll walks the screen store through its one read and one write port:
// it copies all rows but one in ST_SCROLL, then blanks the last row in ST_BLANK;
// a put that scrolls then writes its character in ST_POST.
// Clear writes every cell once, in ST_BLANK.
// After reset a clearing pass (ST_INIT) writes every cell before in_ready rises.
// A stalled result holds in the output register; the next transaction is still taken.
module text_console_writer #(
	parameter int COLUMNS = 80,
	parameter int ROWS    = 25,
	localparam int CELLS  = COLUMNS * ROWS,
	localparam int POS_W  = $clog2(CELLS + 1)
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [7:0]       cfg_wdata,
	input  logic             in_valid,
	output logic             in_ready,
	input  logic [1:0]       operation,
	input  logic [7:0]       char_code,
	input  logic [POS_W-1:0] cell_address,
	output logic             out_valid,
	input  logic             out_ready,
	output logic [POS_W-1:0] cursor_position,
	output logic [7:0]       read_char,
	output logic [7:0]       read_attribute
);
	import tcw_pkg::*;

	localparam int ADDR_W = $clog2(CELLS);
	localparam int COL_W  = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;
	localparam logic [POS_W-1:0] CELLS_P    = POS_W'(CELLS);
	localparam logic [POS_W-1:0] COLS_P     = POS_W'(COLUMNS);
	localparam logic [POS_W-1:0] LAST_ROW_P = POS_W'(CELLS - COLUMNS);
	localparam logic [COL_W-1:0] LAST_COL   = COL_W'(COLUMNS - 1);

	state_t state_q, state_d;
	logic [7:0]       attr_q;
	logic [POS_W-1:0] cursor_q;
	logic [COL_W-1:0] col_q;
	logic [POS_W-1:0] ptr_q;
	logic             post_q;
	logic [7:0]       ch_q;
	logic             is_read_q;
	logic             copy_s1;
	logic [ADDR_W-1:0] waddr_s1;
	logic             out_valid_q;
	logic [POS_W-1:0] out_cursor_q;
	logic [7:0]       out_char_q;
	logic [7:0]       out_attr_q;

	logic accept;
	op_t  op;
	logic past_end;
	logic addr_ok;
	logic [POS_W:0]   row_next;
	logic [POS_W:0]   row_back;
	logic             nl_wrap;
	logic [7:0]       put_ch;
	logic             put_nl;
	logic [COL_W-1:0] col_inc;
	logic             ptr_end;
	logic             ptr_last;
	logic             out_load;

	logic              mem_we;
	logic [ADDR_W-1:0] mem_waddr;
	cell_t             mem_wdata;
	logic              mem_re;
	logic [ADDR_W-1:0] mem_raddr;
	cell_t             mem_rdata;

	tcw_screen_ram #(
		.DEPTH  (CELLS),
		.ADDR_W (ADDR_W)
	) u_ram (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	assign accept   = in_valid && in_ready;
	assign op       = op_t'(operation);
	assign past_end = cursor_q >= CELLS_P;
	assign addr_ok  = cell_address < CELLS_P;
	assign row_next = {1'b0, cursor_q} - (POS_W+1)'(col_q) + (POS_W+1)'(COLUMNS);
	assign row_back = row_next - (POS_W+1)'(COLUMNS);
	assign nl_wrap  = row_next >= (POS_W+1)'(CELLS);
	assign put_ch   = (state_q == ST_POST) ? ch_q : char_code;
	assign put_nl   = put_ch == NEWLINE_CODE;
	assign col_inc  = (col_q == LAST_COL) ? '0 : col_q + 1'b1;
	assign ptr_end  = ptr_q == CELLS_P;
	assign ptr_last = ptr_q == CELLS_P - 1'b1;

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_INIT: begin
				if (ptr_last) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (accept) begin
					case (op)
						OP_PUT:     state_d = past_end ? ST_SCROLL : ST_RESP;
						OP_NEWLINE: state_d = nl_wrap ? ST_SCROLL : ST_RESP;
						OP_CLEAR:   state_d = ST_BLANK;
						default:    state_d = ST_RESP;
					endcase
				end
			end
			ST_SCROLL: begin
				if (ptr_end) state_d = ST_BLANK;
			end
			ST_BLANK: begin
				if (ptr_last) state_d = post_q ? ST_POST : ST_RESP;
			end
			ST_POST: state_d = ST_RESP;
			ST_RESP: begin
				if (!out_valid_q || out_ready) state_d = ST_IDLE;
			end
			default: state_d = ST_INIT;
		endcase
	end

	always_comb begin
		in_ready  = 1'b0;
		mem_we    = 1'b0;
		mem_waddr = ptr_q[ADDR_W-1:0];
		mem_wdata = '{attr: attr_q, code: BLANK_CODE};
		mem_re    = 1'b0;
		mem_raddr = ptr_q[ADDR_W-1:0];
		out_load  = 1'b0;
		case (state_q)
			ST_INIT: begin
				mem_we    = 1'b1;
				mem_wdata = '{attr: RESET_ATTR, code: BLANK_CODE};
			end
			ST_IDLE: begin
				in_ready = 1'b1;
				if (accept && op == OP_PUT && !past_end && !put_nl) begin
					mem_we    = 1'b1;
					mem_waddr = cursor_q[ADDR_W-1:0];
					mem_wdata = '{attr: attr_q, code: put_ch};
				end
				if (accept && op == OP_READ && addr_ok) begin
					mem_re    = 1'b1;
					mem_raddr = cell_address[ADDR_W-1:0];
				end
			end
			ST_SCROLL: begin
				mem_re = !ptr_end;
				if (copy_s1) begin
					mem_we    = 1'b1;
					mem_waddr = waddr_s1;
					mem_wdata = mem_rdata;
				end
			end
			ST_BLANK: mem_we = 1'b1;
			ST_POST: begin
				if (!put_nl) begin
					mem_we    = 1'b1;
					mem_waddr = cursor_q[ADDR_W-1:0];
					mem_wdata = '{attr: attr_q, code: put_ch};
				end
			end
			ST_RESP: out_load = !out_valid_q || out_ready;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_INIT;
			attr_q      <= RESET_ATTR;
			cursor_q    <= '0;
			col_q       <= '0;
			ptr_q       <= '0;
			post_q      <= 1'b0;
			copy_s1     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			copy_s1 <= 1'b0;
			if (cfg_we) begin
				attr_q <= cfg_wdata;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_INIT: ptr_q <= ptr_q + 1'b1;
				ST_IDLE: begin
					if (accept) begin
						post_q <= 1'b0;
						case (op)
							OP_PUT: begin
								if (past_end) begin
									cursor_q <= LAST_ROW_P;
									col_q    <= '0;
									ptr_q    <= COLS_P;
									post_q   <= 1'b1;
								end else if (put_nl) begin
									cursor_q <= row_next[POS_W-1:0];
									col_q    <= '0;
								end else begin
									cursor_q <= cursor_q + 1'b1;
									col_q    <= col_inc;
								end
							end
							OP_NEWLINE: begin
								col_q <= '0;
								if (nl_wrap) begin
									cursor_q <= row_back[POS_W-1:0];
									ptr_q    <= COLS_P;
								end else begin
									cursor_q <= row_next[POS_W-1:0];
								end
							end
							OP_CLEAR: begin
								cursor_q <= '0;
								col_q    <= '0;
								ptr_q    <= '0;
							end
							default: ;
						endcase
					end
				end
				ST_SCROLL: begin
					copy_s1 <= !ptr_end;
					ptr_q   <= ptr_end ? LAST_ROW_P : ptr_q + 1'b1;
				end
				ST_BLANK: ptr_q <= ptr_q + 1'b1;
				ST_POST: begin
					post_q <= 1'b0;
					if (put_nl) begin
						cursor_q <= row_next[POS_W-1:0];
						col_q    <= '0;
					end else begin
						cursor_q <= cursor_q + 1'b1;
						col_q    <= col_inc;
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			ch_q      <= char_code;
			is_read_q <= (op == OP_READ) && addr_ok;
		end
		waddr_s1 <= ADDR_W'(ptr_q - COLS_P);
		if (out_load) begin
			out_cursor_q <= cursor_q;
			out_char_q   <= is_read_q ? mem_rdata.code : 8'd0;
			out_attr_q   <= is_read_q ? mem_rdata.attr : 8'd0;
		end
	end

	assign out_valid       = out_valid_q;
	assign cursor_position = out_cursor_q;
	assign read_char       = out_char_q;
	assign read_attribute  = out_attr_q;

endmodule

// ===== rtl/tcw_checker.sv =====
`include "text_console_writer_assert.svh"

module tcw_checker #(
	parameter int COLUMNS = 80,
	parameter int ROWS    = 25,
	localparam int CELLS  = COLUMNS * ROWS,
	localparam int POS_W  = $clog2(CELLS + 1)
) (
	input logic             clk,
	input logic             arst_n,
	input logic             in_valid,
	input logic             in_ready,
	input logic             out_valid,
	input logic             out_ready,
	input logic [POS_W-1:0] cursor_position,
	input logic [7:0]       read_char,
	input logic [7:0]       read_attribute
);

	localparam logic [POS_W-1:0] CELLS_P = POS_W'(CELLS);

	logic              in_take;
	logic              out_stall;
	logic [POS_W+15:0] out_word;

	assign in_take   = in_valid && in_ready;
	assign out_stall = out_valid && !out_ready;
	assign out_word  = {cursor_position, read_char, read_attribute};

	`TCW_ASSERT_NEXT(a_out_hold, clk, arst_n, out_stall, out_valid, "result dropped while stalled")
	`TCW_ASSERT_NEXT(a_out_stable, clk, arst_n, out_stall, $stable(out_word), "stalled result changed")
	`TCW_ASSERT_NEXT(a_one_in_flight, clk, arst_n, in_take, !in_ready, "transaction taken while busy")
	`TCW_ASSERT_NOW(a_cursor_range, clk, arst_n, out_valid, cursor_position <= CELLS_P, "cursor past end")

endmodule

bind text_console_writer tcw_checker #(
	.COLUMNS (COLUMNS),
	.ROWS    (ROWS)
) u_tcw_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.in_valid        (in_valid),
	.in_ready        (in_ready),
	.out_valid       (out_valid),
	.out_ready       (out_ready),
	.cursor_position (cursor_position),
	.read_char       (read_char),
	.read_attribute  (read_attribute)
);
